>>> hdl/cau_pkg.sv
// shared types and constants of the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int DW  = 32;
  localparam int FB  = 16;
  localparam int PW  = 2 * DW;
  localparam int VW  = 2 * DW + 2;
  localparam int DNW = 2 * DW;
  localparam int QB  = DW + 1;
  localparam int RW  = DNW + QB;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_NEG  = 3'd5,
    OP_EQ   = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } cau_cmd_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 is_equal;
    logic                 div_by_zero;
    logic                 saturated;
  } cau_res_t;

  typedef struct packed {
    op_t                  op;
    logic                 dz;
    logic                 eq;
    logic                 re_neg;
    logic                 im_neg;
    logic                 re_big;
    logic                 im_big;
    logic signed [VW-1:0] re_v;
    logic signed [VW-1:0] im_v;
    logic [DNW-1:0]       den;
    logic [RW-1:0]        re_rem;
    logic [RW-1:0]        im_rem;
    logic [QB-1:0]        re_q;
    logic [QB-1:0]        im_q;
  } cau_stage_t;

endpackage

>>> hdl/cau_front.sv
// front end: products, exact sums and divider setup, three register stages
// depends on cau_pkg
module cau_front import cau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  cau_cmd_t   cmd,
  output logic       out_vld,
  output cau_stage_t out
);

  logic signed [DW-1:0] c_ar, c_ai, c_br, c_bi;
  logic signed [PW-1:0] m_rr, m_ii, m_ir, m_ri, m_br, m_bi;

  logic                 a_vld;
  op_t                  a_op;
  logic signed [DW-1:0] a_ar, a_ai, a_br, a_bi;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, p_br, p_bi;

  logic                 b_vld;
  op_t                  b_op;
  logic signed [VW-1:0] b_re, b_im;
  logic [DNW-1:0]       b_den;
  logic                 b_eq;

  logic signed [VW-1:0] re_next, im_next;
  logic [DNW-1:0]       den_next;
  logic                 eq_next;
  cau_stage_t           out_next;
  logic [VW-1:0]        mag_re, mag_im;
  logic [RW-1:0]        dlim;

  assign c_ar = cmd.a_re;
  assign c_ai = cmd.a_im;
  assign c_br = cmd.b_re;
  assign c_bi = cmd.b_im;
  assign m_rr = c_ar * c_br;
  assign m_ii = c_ai * c_bi;
  assign m_ir = c_ai * c_br;
  assign m_ri = c_ar * c_bi;
  assign m_br = c_br * c_br;
  assign m_bi = c_bi * c_bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op <= op_t'(cmd.op);
      a_ar <= c_ar;
      a_ai <= c_ai;
      a_br <= c_br;
      a_bi <= c_bi;
      p_rr <= m_rr;
      p_ii <= m_ii;
      p_ir <= m_ir;
      p_ri <= m_ri;
      p_br <= m_br;
      p_bi <= m_bi;
    end
  end

  // exact sums at full width
  always_comb begin
    re_next  = '0;
    im_next  = '0;
    eq_next  = 1'b0;
    den_next = DNW'($unsigned(p_br)) + DNW'($unsigned(p_bi));
    case (a_op)
      OP_ADD: begin
        re_next = VW'(a_ar) + VW'(a_br);
        im_next = VW'(a_ai) + VW'(a_bi);
      end
      OP_SUB: begin
        re_next = VW'(a_ar) - VW'(a_br);
        im_next = VW'(a_ai) - VW'(a_bi);
      end
      OP_MUL: begin
        re_next = VW'(p_rr) - VW'(p_ii);
        im_next = VW'(p_ir) + VW'(p_ri);
      end
      OP_DIV: begin
        re_next = VW'(p_rr) + VW'(p_ii);
        im_next = VW'(p_ir) - VW'(p_ri);
      end
      OP_CONJ: begin
        re_next = VW'(a_ar);
        im_next = -VW'(a_ai);
      end
      OP_NEG: begin
        re_next = -VW'(a_ar);
        im_next = -VW'(a_ai);
      end
      OP_EQ: begin
        eq_next = (a_ar == a_br) && (a_ai == a_bi);
      end
      default: begin
        re_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op  <= a_op;
      b_re  <= re_next;
      b_im  <= im_next;
      b_den <= den_next;
      b_eq  <= eq_next;
    end
  end

  // magnitudes, truncation toward zero and divider setup
  always_comb begin
    mag_re          = b_re[VW-1] ? $unsigned(-b_re) : $unsigned(b_re);
    mag_im          = b_im[VW-1] ? $unsigned(-b_im) : $unsigned(b_im);
    dlim            = RW'(b_den) << QB;
    out_next        = '0;
    out_next.op     = b_op;
    out_next.eq     = b_eq;
    out_next.den    = b_den;
    out_next.re_v   = b_re;
    out_next.im_v   = b_im;
    out_next.re_neg = b_re[VW-1];
    out_next.im_neg = b_im[VW-1];
    out_next.re_rem = RW'(mag_re) << FB;
    out_next.im_rem = RW'(mag_im) << FB;
    out_next.re_big = (RW'(mag_re) << FB) >= dlim;
    out_next.im_big = (RW'(mag_im) << FB) >= dlim;
    out_next.dz     = (b_op == OP_DIV) && (b_den == '0);
    if (b_op == OP_MUL) begin
      out_next.re_v = b_re[VW-1] ? -$signed(mag_re >> FB) : $signed(mag_re >> FB);
      out_next.im_v = b_im[VW-1] ? -$signed(mag_im >> FB) : $signed(mag_im >> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= out_next;
    end
  end

endmodule

>>> hdl/cau_div_cell.sv
// one restoring divider cell: one quotient bit for each part per item
// depends on cau_pkg
module cau_div_cell import cau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  cau_stage_t in,
  output logic       out_vld,
  output cau_stage_t out
);

  logic [RW-1:0] dsh;
  logic          ge_re, ge_im;
  logic [RW-1:0] rre, rim;
  cau_stage_t    out_next;

  always_comb begin
    dsh             = RW'(in.den) << (QB - 1);
    ge_re           = in.re_rem >= dsh;
    ge_im           = in.im_rem >= dsh;
    rre             = ge_re ? (in.re_rem - dsh) : in.re_rem;
    rim             = ge_im ? (in.im_rem - dsh) : in.im_rem;
    out_next        = in;
    out_next.re_rem = rre << 1;
    out_next.im_rem = rim << 1;
    out_next.re_q   = {in.re_q[QB-2:0], ge_re};
    out_next.im_q   = {in.im_q[QB-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= out_next;
    end
  end

endmodule

>>> hdl/cau_back.sv
// back end: sign of quotients, saturation and flags into the output register
// depends on cau_pkg
module cau_back import cau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  cau_stage_t in,
  output logic       out_vld,
  output cau_res_t   out
);

  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  logic                 have, is_div;
  logic signed [VW-1:0] vre, vim;
  logic                 big_re, big_im;
  logic [DW-1:0]        ore, oim;
  logic                 sre, sim;
  cau_res_t             out_next;

  function automatic logic [DW:0] clamp(input logic signed [VW-1:0] v, input logic big);
    logic fits;
    fits = (&v[VW-1:DW-1]) || (~|v[VW-1:DW-1]);
    if (big || !fits) begin
      return {1'b1, (v[VW-1] ? SMIN : SMAX)};
    end
    return {1'b0, v[DW-1:0]};
  endfunction

  always_comb begin
    is_div = in.op == OP_DIV;
    have   = (in.op == OP_ADD) || (in.op == OP_SUB) || (in.op == OP_MUL) ||
             (in.op == OP_CONJ) || (in.op == OP_NEG) || (is_div && !in.dz);
    vre    = in.re_v;
    vim    = in.im_v;
    big_re = 1'b0;
    big_im = 1'b0;
    if (is_div) begin
      vre    = in.re_neg ? -$signed(VW'(in.re_q)) : $signed(VW'(in.re_q));
      vim    = in.im_neg ? -$signed(VW'(in.im_q)) : $signed(VW'(in.im_q));
      big_re = in.re_big;
      big_im = in.im_big;
      if (big_re) vre[VW-1] = in.re_neg;
      if (big_im) vim[VW-1] = in.im_neg;
    end
    {sre, ore} = clamp(vre, big_re);
    {sim, oim} = clamp(vim, big_im);
    out_next             = '0;
    out_next.is_equal    = (in.op == OP_EQ) && in.eq;
    out_next.div_by_zero = is_div && in.dz;
    if (have) begin
      out_next.res_re    = ore;
      out_next.res_im    = oim;
      out_next.saturated = sre || sim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= out_next;
    end
  end

endmodule

>>> hdl/complex_arith_unit_top.sv
// top level of the complex arithmetic unit: front end, divider cell row, back end
// depends on cau_pkg, cau_front, cau_div_cell, cau_back
//
// Complex ALU on signed Q16.16 pairs: add, subtract, multiply, divide, conjugate,
// negate and compare equal, with saturation and divide-by-zero flags. One item is
// accepted every cycle while the pipe does not stall; each item passes three front
// stages for products and sums, one divider cell per quotient bit, 33 cells, and
// the output register. The divider cell row is the longest part. The whole pipe
// stalls only while a result waits in the output register and res_ready is low.
module complex_arith_unit_top import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  cau_cmd_t cmd,
  output logic     res_valid,
  input  logic     res_ready,
  output cau_res_t res
);

  logic       en;
  logic       cvld [0:QB];
  cau_stage_t cst  [0:QB];

  assign en        = !res_valid || res_ready;
  assign cmd_ready = en;

  cau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (cmd_valid),
    .cmd     (cmd),
    .out_vld (cvld[0]),
    .out     (cst[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (cvld[i]),
      .in      (cst[i]),
      .out_vld (cvld[i+1]),
      .out     (cst[i+1])
    );
  end

  cau_back u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (cvld[QB]),
    .in      (cst[QB]),
    .out_vld (res_valid),
    .out     (res)
  );

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.div_by_zero |-> res.res_re == '0 && res.res_im == '0 && !res.saturated)
    else $error("divide by zero item carries nonzero result");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.is_equal && res.div_by_zero))
    else $error("equal and divide-by-zero flags both set");

  a_eq_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_equal |-> res.res_re == '0 && res.res_im == '0)
    else $error("equal item carries nonzero result");

  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule
